// ===== hw/rtl/vzd_pkg.sv =====
// shared types and constants for the varint / zigzag decoder
package vzd_pkg;

  // bytes allowed in one value, bits per byte group
  localparam int unsigned MaxBytes  = 10;
  localparam int unsigned GroupBits = 7;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned PosW      = 4;
  localparam int unsigned ShiftW    = 6;

  // position of the last byte a value may have
  localparam logic [PosW-1:0] LastPos = PosW'(MaxBytes - 1);

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_OVERLONG = 2'd2
  } status_t;

  // result of one decode step
  typedef struct packed {
    logic              emit;
    logic [ValueW-1:0] value;
    status_t           status;
  } vzd_result_t;

endpackage

// ===== hw/rtl/vzd_core.sv =====
// decode state (accumulator, byte position, sticky error) and per-byte update
module vzd_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               data_byte,
  input  logic                     zigzag_mode,
  input  logic                     buffer_end,
  output vzd_pkg::vzd_result_t     result
);

  logic [vzd_pkg::ValueW-1:0] accumulator;
  logic [vzd_pkg::ValueW-1:0] accumulator_next;
  logic [vzd_pkg::PosW-1:0]   byte_position;
  logic [vzd_pkg::PosW-1:0]   byte_position_next;
  logic                       sticky_error;
  logic                       sticky_error_next;

  logic [vzd_pkg::ShiftW-1:0] shift;
  logic [vzd_pkg::ValueW-1:0] merged;
  logic                       cont;
  logic                       at_last;

  // shift for this byte group, 7 * position (at most 63)
  assign shift   = vzd_pkg::ShiftW'(byte_position) * vzd_pkg::ShiftW'(vzd_pkg::GroupBits);
  assign merged  = accumulator | (vzd_pkg::ValueW'(data_byte[6:0]) << shift);
  assign cont    = data_byte[7];
  assign at_last = (byte_position == vzd_pkg::LastPos);

  // result and next state for the byte at the input
  always_comb begin
    result             = '0;
    result.status      = vzd_pkg::ST_OK;
    accumulator_next   = merged;
    byte_position_next = byte_position + 1'b1;
    sticky_error_next  = sticky_error;
    if (sticky_error) begin
      accumulator_next   = accumulator;
      byte_position_next = byte_position;
    end else if (!cont) begin
      result.emit        = 1'b1;
      result.value       = zigzag_mode ?
                           ((merged >> 1) ^ (-{{(vzd_pkg::ValueW-1){1'b0}}, merged[0]})) :
                           merged;
      accumulator_next   = '0;
      byte_position_next = '0;
    end else if (at_last) begin
      result.emit        = 1'b1;
      result.status      = vzd_pkg::ST_OVERLONG;
      accumulator_next   = '0;
      byte_position_next = '0;
      sticky_error_next  = 1'b1;
    end else if (buffer_end) begin
      result.emit        = 1'b1;
      result.status      = vzd_pkg::ST_TRUNC;
      accumulator_next   = '0;
      byte_position_next = '0;
      sticky_error_next  = 1'b1;
    end
  end

  // state registers, updated when a byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      byte_position <= '0;
      sticky_error  <= 1'b0;
    end else if (step) begin
      accumulator   <= accumulator_next;
      byte_position <= byte_position_next;
      sticky_error  <= sticky_error_next;
    end
  end

endmodule

// ===== hw/rtl/varint_zigzag_decoder_top.sv =====
// LEB128 varint decoder with optional zigzag: input register, decode, result register
//
// Input channel: one encoded byte per request (data_byte, zigzag_mode,
// buffer_end), taken when in_valid is high and in_stall is low.
// Output channel: one decoded value per request (value, status), taken when
// out_valid is high and out_stall is low. A byte that continues a value gives
// no output; the final byte gives status 0, a continued byte marked as the
// buffer end gives status 1, a tenth continued byte gives status 2. After an
// error every byte is consumed and dropped until reset.
// Throughput: one byte per cycle, set by the single accumulator update, except
// while a byte that gives a result waits for a stalled receiver. A result
// passes from its final byte through the input register and then the result
// register before it shows on out_valid.
// Reset clears the accumulator, byte position, error flag and both
// registers' valid bits; the block accepts a byte in the first cycle after.
// When the receiver stalls, the held result stays put; bytes that give no
// result keep flowing, and a byte that gives a result waits in the input
// register, which then raises in_stall.
module varint_zigzag_decoder_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            zigzag_mode,
  input  logic                            buffer_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [vzd_pkg::ValueW-1:0]      value,
  output logic [1:0]                      status
);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_zig;
  logic                 s1_end;
  logic                 out_free;
  logic                 s1_adv;
  logic                 in_accept;
  vzd_pkg::vzd_result_t res;

  // decode logic and value state
  vzd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_adv),
    .data_byte   (s1_byte),
    .zigzag_mode (s1_zig),
    .buffer_end  (s1_end),
    .result      (res)
  );

  // handshake control
  assign out_free  = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && (!res.emit || out_free);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= data_byte;
      s1_zig  <= zigzag_mode;
      s1_end  <= buffer_end;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && res.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) begin
      value  <= res.value;
      status <= res.status;
    end
  end

endmodule
